FILE: design/pbie_pkg.sv
// shared types and codes for the plc bit instruction executor
package pbie_pkg;

    localparam int OP_W       = 4;
    localparam int TKIND_W    = 2;
    localparam int SKIND_W    = 3;
    localparam int IDX_W      = 10;
    localparam int SLOT_W     = 8;
    localparam int PRESET_W   = 16;
    localparam int MS_W       = 16;
    localparam int READ_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_SCAN_START   = 4'd0,
        OP_SET_INPUT    = 4'd1,
        OP_ASSIGN       = 4'd2,
        OP_COND_ASSIGN  = 4'd3,
        OP_TON          = 4'd4,
        OP_CTU          = 4'd5,
        OP_RST_TIMER    = 4'd6,
        OP_RST_COUNTER  = 4'd7,
        OP_READ_BIT     = 4'd8,
        OP_READ_TIMER   = 4'd9,
        OP_READ_COUNTER = 4'd10
    } t_op;

    typedef enum logic [TKIND_W-1:0] {
        TGT_ACC = 2'd0,
        TGT_X   = 2'd1,
        TGT_Y   = 2'd2,
        TGT_M   = 2'd3
    } t_tgt_kind;

    typedef enum logic [SKIND_W-1:0] {
        SRC_ACC      = 3'd0,
        SRC_X        = 3'd1,
        SRC_Y        = 3'd2,
        SRC_M        = 3'd3,
        SRC_TMR_DONE = 3'd4,
        SRC_CTR_DONE = 3'd5
    } t_src_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONT_MODE  = 1'd0,
        CFG_CYCLE_TIME = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // write strobes and result bits from the execute logic
    typedef struct packed {
        logic acc;
        logic bit_val;
        logic x_we;
        logic y_we;
        logic mk_we;
        logic slot_we;
        logic scan_we;
        logic rbit;
        logic status;
    } t_ctl;

endpackage

FILE: design/pbie_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
module pbie_ram
    import pbie_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/pbie_alu.sv
// execute logic: evaluates one instruction against read data and the bit images
module pbie_alu
    import pbie_pkg::*;
#(
    parameter int IO_BITS     = 16,
    parameter int MARKER_BITS = 1024,
    parameter int SLOTS       = 256,
    parameter int VALUE_BITS  = 16,
    localparam int SE_W = 4 * VALUE_BITS + 2
) (
    input  logic [OP_W-1:0]       i_op,
    input  logic [TKIND_W-1:0]    i_tkind,
    input  logic [IDX_W-1:0]      i_tidx,
    input  logic [SKIND_W-1:0]    i_skind,
    input  logic [IDX_W-1:0]      i_sidx,
    input  logic                  i_sinv,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [PRESET_W-1:0]   i_preset,
    input  logic                  i_bval,
    input  logic [MS_W-1:0]       i_elapsed,
    input  logic                  i_acc,
    input  logic [IO_BITS-1:0]    i_x_img,
    input  logic [IO_BITS-1:0]    i_y_img,
    input  logic                  i_mark_bit,
    input  logic [SE_W-1:0]       i_slot_ent,
    input  logic [MS_W-1:0]       i_scan,
    input  logic                  i_cont_mode,
    input  logic [MS_W-1:0]       i_cycle_time,
    output t_ctl                  o_ctl,
    output logic [SE_W-1:0]       o_slot_ent,
    output logic [MS_W-1:0]       o_scan,
    output logic [VALUE_BITS-1:0] o_rval
);

    localparam int VB    = VALUE_BITS;
    localparam int IO_AW = (IO_BITS > 1) ? $clog2(IO_BITS) : 1;
    localparam int CLIM  = 0;
    localparam int CPREV = VB;
    localparam int CVAL  = VB + 1;
    localparam int TLIM  = 2 * VB + 1;
    localparam int TACT  = 3 * VB + 1;
    localparam int TVAL  = 3 * VB + 2;
    localparam logic [31:0] VMAX32 = 32'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [VB-1:0] VMAX = VB'(VMAX32);

    logic [VB-1:0] tval, tlim, cval, clim, lim;
    logic          tact, cprev;
    logic [VB-1:0] n_tval, n_tlim, n_cval, n_clim;
    logic          n_tact, n_cprev;
    logic          sidx_io_ok, sidx_mk_ok, sidx_sl_ok, tidx_io_ok, tidx_mk_ok, slot_ok;
    logic          tdone, cdone, src_bit, tgt_ok, wr_tgt;
    logic [32:0]   tsum;
    t_ctl          ctl;

    assign tval  = i_slot_ent[TVAL +: VB];
    assign tact  = i_slot_ent[TACT];
    assign tlim  = i_slot_ent[TLIM +: VB];
    assign cval  = i_slot_ent[CVAL +: VB];
    assign cprev = i_slot_ent[CPREV];
    assign clim  = i_slot_ent[CLIM +: VB];

    assign sidx_io_ok = 32'(i_sidx) < 32'(IO_BITS);
    assign sidx_mk_ok = 32'(i_sidx) < 32'(MARKER_BITS);
    assign sidx_sl_ok = 32'(i_sidx) < 32'(SLOTS);
    assign tidx_io_ok = 32'(i_tidx) < 32'(IO_BITS);
    assign tidx_mk_ok = 32'(i_tidx) < 32'(MARKER_BITS);
    assign slot_ok    = 32'(i_slot) < 32'(SLOTS);

    // preset saturates to the largest value a slot can hold
    assign lim = (32'(i_preset) > VMAX32) ? VMAX : VB'(i_preset);

    assign tdone = (tlim != '0) ? (tval >= tlim) : tact;
    assign cdone = (clim != '0) ? (cval >= clim) : (cval != '0);

    always_comb begin
        case (i_skind)
            SRC_ACC:      src_bit = i_acc;
            SRC_X:        src_bit = sidx_io_ok & i_x_img[IO_AW'(i_sidx)];
            SRC_Y:        src_bit = sidx_io_ok & i_y_img[IO_AW'(i_sidx)];
            SRC_M:        src_bit = sidx_mk_ok & i_mark_bit;
            SRC_TMR_DONE: src_bit = sidx_sl_ok & tdone;
            SRC_CTR_DONE: src_bit = sidx_sl_ok & cdone;
            default:      src_bit = 1'b0;
        endcase
    end

    always_comb begin
        case (i_tkind)
            TGT_ACC: tgt_ok = 1'b1;
            TGT_X:   tgt_ok = tidx_io_ok;
            TGT_Y:   tgt_ok = tidx_io_ok;
            default: tgt_ok = tidx_mk_ok;
        endcase
    end

    always_comb begin
        n_tval  = tval;
        n_tact  = tact;
        n_tlim  = tlim;
        n_cval  = cval;
        n_cprev = cprev;
        n_clim  = clim;
        ctl     = '0;
        ctl.acc = i_acc;
        o_rval  = '0;
        o_scan  = i_scan;
        tsum    = '0;
        wr_tgt  = 1'b0;
        unique case (i_op)
            OP_SCAN_START: begin
                ctl.scan_we = 1'b1;
                o_scan = (i_cont_mode && i_cycle_time > i_elapsed) ? i_cycle_time : i_elapsed;
            end
            OP_SET_INPUT: begin
                ctl.bit_val = i_bval;
                ctl.x_we    = tidx_io_ok;
            end
            OP_ASSIGN: begin
                ctl.bit_val = src_bit ^ i_sinv;
                wr_tgt      = 1'b1;
            end
            OP_COND_ASSIGN: begin
                ctl.bit_val = i_bval;
                wr_tgt      = i_acc;
            end
            OP_TON: begin
                if (slot_ok) begin
                    ctl.slot_we = 1'b1;
                    n_tlim = lim;
                    if (i_acc) begin
                        n_tact = 1'b1;
                        if (lim == '0) begin
                            n_tval  = '0;
                            ctl.acc = 1'b1;
                        end else begin
                            // accumulate scan time, capped at the preset
                            if (tval < lim) begin
                                tsum   = 33'(tval) + 33'(i_scan);
                                n_tval = (tsum > 33'(lim)) ? lim : VB'(tsum);
                            end
                            ctl.acc = n_tval >= lim;
                        end
                    end else begin
                        n_tact  = 1'b0;
                        n_tval  = '0;
                        ctl.acc = 1'b0;
                    end
                end
            end
            OP_CTU: begin
                if (slot_ok) begin
                    ctl.slot_we = 1'b1;
                    n_clim = lim;
                    // count on a rising edge of the rung power
                    if (i_acc && !cprev && cval != VMAX) begin
                        n_cval = cval + 1'b1;
                    end
                    n_cprev = i_acc;
                    ctl.acc = (lim != '0) ? (n_cval >= lim) : i_acc;
                end
            end
            OP_RST_TIMER: begin
                if (slot_ok && i_acc) begin
                    ctl.slot_we = 1'b1;
                    n_tval = '0;
                    n_tact = 1'b0;
                end
            end
            OP_RST_COUNTER: begin
                if (slot_ok && i_acc) begin
                    ctl.slot_we = 1'b1;
                    n_cval  = '0;
                    n_cprev = 1'b0;
                end
            end
            OP_READ_BIT: begin
                ctl.rbit = (i_skind == SRC_ACC) ? 1'b0 : src_bit;
            end
            OP_READ_TIMER: begin
                o_rval = slot_ok ? tval : '0;
            end
            OP_READ_COUNTER: begin
                o_rval = slot_ok ? cval : '0;
            end
            default: begin
            end
        endcase
        if (wr_tgt) begin
            ctl.status = !tgt_ok;
            case (i_tkind)
                TGT_ACC: ctl.acc   = ctl.bit_val;
                TGT_X:   ctl.x_we  = tidx_io_ok;
                TGT_Y:   ctl.y_we  = tidx_io_ok;
                default: ctl.mk_we = tidx_mk_ok;
            endcase
        end
    end

    assign o_ctl      = ctl;
    assign o_slot_ent = {n_tval, n_tact, n_tlim, n_cval, n_cprev, n_clim};

endmodule

FILE: design/plc_bit_instruction_executor.sv
// top level: sequencer, bit images, configuration and the two state memories
//
// usage
//   instruction channel: drive the fields and raise start; a request is taken at the
//   rising edge where start is high and busy is low
//   result channel: o_result_valid is high for one cycle with o_accumulator_out,
//   o_read_bit, o_read_value and o_status; the receiver cannot stall and must take it
//   configuration: i_cfg_we, i_cfg_idx, i_cfg_data write a register at any edge
//   (0 continuous mode, 1 cycle time in ms)
// timing
//   the result is shown in the second cycle after the request is taken, and busy is
//   high for the one cycle in between; a new request may be taken in the result cycle,
//   so one instruction completes every 2 cycles
//   the 2 cycles are the registered read of the slot and marker memories followed by
//   the modify and write-back of the same entry
// reset
//   i_rst_n low clears the accumulator, bit images, scan time and configuration;
//   afterwards busy stays high for max(SLOTS, MARKER_BITS) cycles (1024 by default)
//   while both memories are swept to zero
module plc_bit_instruction_executor
    import pbie_pkg::*;
#(
    parameter int IO_BITS     = 16,
    parameter int MARKER_BITS = 1024,
    parameter int SLOTS       = 256,
    parameter int VALUE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [TKIND_W-1:0]    i_target_kind,
    input  logic [IDX_W-1:0]      i_target_index,
    input  logic [SKIND_W-1:0]    i_source_kind,
    input  logic [IDX_W-1:0]      i_source_index,
    input  logic                  i_source_invert,
    input  logic [SLOT_W-1:0]     i_slot_index,
    input  logic [PRESET_W-1:0]   i_preset_value,
    input  logic                  i_bool_value,
    input  logic [MS_W-1:0]       i_elapsed_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic                  o_accumulator_out,
    output logic                  o_read_bit,
    output logic [READ_W-1:0]     o_read_value,
    output logic                  o_status
);

    localparam int SE_W  = 4 * VALUE_BITS + 2;
    localparam int IO_AW = (IO_BITS > 1) ? $clog2(IO_BITS) : 1;
    localparam int MK_AW = (MARKER_BITS > 1) ? $clog2(MARKER_BITS) : 1;
    localparam int SL_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CLR_N = (SLOTS > MARKER_BITS) ? SLOTS : MARKER_BITS;
    localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    t_state                 r_state, n_state;
    logic [CLR_W-1:0]       r_clr_addr;
    logic                   accept, clearing, executing, clr_last;

    logic [OP_W-1:0]        r_op;
    logic [TKIND_W-1:0]     r_tkind;
    logic [IDX_W-1:0]       r_tidx;
    logic [SKIND_W-1:0]     r_skind;
    logic [IDX_W-1:0]       r_sidx;
    logic                   r_sinv;
    logic [SLOT_W-1:0]      r_slot;
    logic [PRESET_W-1:0]    r_preset;
    logic                   r_bval;
    logic [MS_W-1:0]        r_elapsed;

    logic                   r_acc;
    logic [IO_BITS-1:0]     r_x_img, r_y_img;
    logic [MS_W-1:0]        r_scan;
    logic                   r_cont_mode;
    logic [MS_W-1:0]        r_cycle_time;

    logic                   r_valid, r_rbit, r_status;
    logic [READ_W-1:0]      r_rval;

    t_ctl                   ctl;
    logic [SE_W-1:0]        slot_rd, slot_wr, slot_wdata;
    logic [MS_W-1:0]        scan_nx;
    logic [VALUE_BITS-1:0]  rval;
    logic                   mark_rd, mark_wdata;
    logic [SL_AW-1:0]       slot_raddr, slot_waddr;
    logic [MK_AW-1:0]       mark_waddr;
    logic                   slot_we, mark_we;
    logic                   src_is_slot;

    // state machine
    assign clr_last = r_clr_addr == CLR_W'(CLR_N - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        accept    = 1'b0;
        clearing  = 1'b0;
        executing = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE: begin
                busy   = 1'b0;
                accept = start;
            end
            ST_EXEC:  executing = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_tkind   <= i_target_kind;
            r_tidx    <= i_target_index;
            r_skind   <= i_source_kind;
            r_sidx    <= i_source_index;
            r_sinv    <= i_source_invert;
            r_slot    <= i_slot_index;
            r_preset  <= i_preset_value;
            r_bval    <= i_bool_value;
            r_elapsed <= i_elapsed_ms;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_mode  <= 1'b0;
            r_cycle_time <= MS_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CONT_MODE:  r_cont_mode  <= i_cfg_data[0];
                CFG_CYCLE_TIME: r_cycle_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // memory ports: reads at request time, write-back at the end of the execute cycle
    assign src_is_slot = (i_operation == OP_ASSIGN) || (i_operation == OP_READ_BIT);
    assign slot_raddr  = src_is_slot ? SL_AW'(i_source_index) : SL_AW'(i_slot_index);

    assign slot_we    = clearing ? (32'(r_clr_addr) < 32'(SLOTS)) : (executing & ctl.slot_we);
    assign slot_waddr = clearing ? SL_AW'(r_clr_addr) : SL_AW'(r_slot);
    assign slot_wdata = clearing ? '0 : slot_wr;

    assign mark_we    = clearing ? (32'(r_clr_addr) < 32'(MARKER_BITS)) : (executing & ctl.mk_we);
    assign mark_waddr = clearing ? MK_AW'(r_clr_addr) : MK_AW'(r_tidx);
    assign mark_wdata = clearing ? 1'b0 : ctl.bit_val;

    pbie_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SE_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (slot_raddr),
        .o_rd_data (slot_rd),
        .i_wr_en   (slot_we),
        .i_wr_addr (slot_waddr),
        .i_wr_data (slot_wdata)
    );

    pbie_ram #(
        .DEPTH (MARKER_BITS),
        .WIDTH (1)
    ) u_mark_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (MK_AW'(i_source_index)),
        .o_rd_data (mark_rd),
        .i_wr_en   (mark_we),
        .i_wr_addr (mark_waddr),
        .i_wr_data (mark_wdata)
    );

    pbie_alu #(
        .IO_BITS     (IO_BITS),
        .MARKER_BITS (MARKER_BITS),
        .SLOTS       (SLOTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_alu (
        .i_op         (r_op),
        .i_tkind      (r_tkind),
        .i_tidx       (r_tidx),
        .i_skind      (r_skind),
        .i_sidx       (r_sidx),
        .i_sinv       (r_sinv),
        .i_slot       (r_slot),
        .i_preset     (r_preset),
        .i_bval       (r_bval),
        .i_elapsed    (r_elapsed),
        .i_acc        (r_acc),
        .i_x_img      (r_x_img),
        .i_y_img      (r_y_img),
        .i_mark_bit   (mark_rd),
        .i_slot_ent   (slot_rd),
        .i_scan       (r_scan),
        .i_cont_mode  (r_cont_mode),
        .i_cycle_time (r_cycle_time),
        .o_ctl        (ctl),
        .o_slot_ent   (slot_wr),
        .o_scan       (scan_nx),
        .o_rval       (rval)
    );

    // accumulator, bit images and scan time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 1'b0;
            r_x_img <= '0;
            r_y_img <= '0;
            r_scan  <= '0;
        end else if (executing) begin
            r_acc <= ctl.acc;
            if (ctl.x_we) begin
                r_x_img[IO_AW'(r_tidx)] <= ctl.bit_val;
            end
            if (ctl.y_we) begin
                r_y_img[IO_AW'(r_tidx)] <= ctl.bit_val;
            end
            if (ctl.scan_we) begin
                r_scan <= scan_nx;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= executing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (executing) begin
            r_rbit   <= ctl.rbit;
            r_status <= ctl.status;
            r_rval   <= READ_W'(rval);
        end
    end

    assign o_result_valid    = r_valid;
    assign o_accumulator_out = r_acc;
    assign o_read_bit        = r_rbit;
    assign o_read_value      = r_rval;
    assign o_status          = r_status;

endmodule
